// ===== rtl/tpe_pkg.sv =====
package tpe_pkg;

	// Fixed transport packet header size
	localparam int unsigned HEADER_BYTES = 4;

	// Header byte positions
	localparam logic [7:0] POS_SYNC   = 8'd0;
	localparam logic [7:0] POS_PID_HI = 8'd1;
	localparam logic [7:0] POS_PID_LO = 8'd2;
	localparam logic [7:0] POS_FLAGS  = 8'd3;

	// Adaptation field control codes
	localparam logic [1:0] AFC_PAYLOAD_ONLY = 2'b01;
	localparam logic [1:0] AFC_ADAPT_PAYLOAD = 2'b11;

	// Configuration register indexes
	localparam logic [1:0] REG_MATCH_PID     = 2'd0;
	localparam logic [1:0] REG_PSI_MODE      = 2'd1;
	localparam logic [1:0] REG_PACKET_LENGTH = 2'd2;

	localparam logic [7:0] PACKET_LENGTH_RST = 8'd188;

	// What the parser expects at the payload offset
	typedef enum logic [1:0] {
		STG_NONE,
		STG_ADAPT,
		STG_PTR,
		STG_DATA
	} stage_t;

	typedef struct packed {
		logic [12:0] match_pid;
		logic        psi_mode;
		logic [7:0]  packet_length;
	} cfg_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       unit_start;
		logic       packet_last;
		logic [3:0] continuity_count;
	} res_t;

endpackage

// ===== rtl/tpe_front.sv =====
module tpe_front (
	input  logic          clk,
	input  logic          arst_n,
	input  tpe_pkg::cfg_t cfg,
	input  logic          accept,
	input  logic [7:0]    data_byte,
	output logic          emit,
	output tpe_pkg::res_t res
);
	import tpe_pkg::*;

	logic [7:0]  pos_q;
	logic [12:0] pid_q;
	logic        start_q;
	logic [3:0]  cc_q;
	logic [8:0]  offset_q;
	stage_t      stage_q;

	logic [7:0]  pos_d;
	logic [12:0] pid_d;
	logic        start_d;
	logic [3:0]  cc_d;
	logic [8:0]  offset_d;
	stage_t      stage_d;

	logic [8:0]  pos9;
	logic [8:0]  pos_inc;
	logic [8:0]  skip_off;
	logic        at_off;
	logic        skip_ptr;
	logic [1:0]  afc;

	assign pos9     = {1'b0, pos_q};
	assign pos_inc  = pos9 + 9'd1;
	assign skip_off = pos_inc + {1'b0, data_byte};
	assign at_off   = (pos9 == offset_q);
	assign skip_ptr = cfg.psi_mode & start_q;
	assign afc      = data_byte[5:4];

	// Next state of the header parser
	always_comb begin
		pid_d    = pid_q;
		start_d  = start_q;
		cc_d     = cc_q;
		offset_d = offset_q;
		stage_d  = stage_q;
		unique case (pos_q)
			POS_SYNC: begin
				stage_d = STG_NONE;
			end
			POS_PID_HI: begin
				start_d = data_byte[6];
				pid_d   = {data_byte[4:0], pid_q[7:0]};
			end
			POS_PID_LO: begin
				pid_d = {pid_q[12:8], data_byte};
			end
			POS_FLAGS: begin
				cc_d     = data_byte[3:0];
				offset_d = 9'(HEADER_BYTES);
				priority if (afc == AFC_ADAPT_PAYLOAD) begin
					stage_d = STG_ADAPT;
				end else if (afc == AFC_PAYLOAD_ONLY) begin
					stage_d = skip_ptr ? STG_PTR : STG_DATA;
				end else begin
					stage_d = STG_NONE;
				end
			end
			default: begin
				// Skip the adaptation field, then the pointer field
				if (stage_q == STG_ADAPT && at_off) begin
					offset_d = skip_off;
					stage_d  = skip_ptr ? STG_PTR : STG_DATA;
				end else if (stage_q == STG_PTR && at_off) begin
					offset_d = skip_off;
					stage_d  = STG_DATA;
				end
			end
		endcase

		// Wrap at the packet end or at the top of the counter
		if (pos_inc >= {1'b0, cfg.packet_length} || pos_q == 8'hFF) begin
			pos_d = POS_SYNC;
		end else begin
			pos_d = pos_inc[7:0];
		end
	end

	// Classification of the current byte
	always_comb begin
		emit = (pos9 >= 9'(HEADER_BYTES)) && (stage_q == STG_DATA) &&
			(pos9 >= offset_q) && (pid_q == cfg.match_pid);
		res.payload_byte     = data_byte;
		res.unit_start       = start_q & at_off;
		res.packet_last      = (pos_inc == {1'b0, cfg.packet_length});
		res.continuity_count = cc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_SYNC;
			pid_q    <= '0;
			start_q  <= 1'b0;
			cc_q     <= '0;
			offset_q <= '0;
			stage_q  <= STG_NONE;
		end else if (accept) begin
			pos_q    <= pos_d;
			pid_q    <= pid_d;
			start_q  <= start_d;
			cc_q     <= cc_d;
			offset_q <= offset_d;
			stage_q  <= stage_d;
		end
	end

endmodule

// ===== rtl/tpe_fifo.sv =====
module tpe_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  tpe_pkg::res_t wr_res,
	input  logic          rd_en,
	output tpe_pkg::res_t rd_res,
	output logic          fifo_full,
	output logic          fifo_empty
);
	import tpe_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	res_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign fifo_full  = (count_q == CW'(DEPTH));
	assign fifo_empty = (count_q == '0);
	assign rd_res     = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_res;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && fifo_full))
		else $error("write into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && fifo_empty))
		else $error("read from empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count beyond depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |=> (count_q == $past(count_q) + 1'b1))
		else $error("fill count lost a write");

endmodule

// ===== rtl/tpe_back.sv =====
module tpe_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fifo_empty,
	input  tpe_pkg::res_t fifo_res,
	output logic          fifo_rd,
	input  logic          pop,
	output logic          empty,
	output tpe_pkg::res_t out_res
);
	import tpe_pkg::*;

	logic valid_q;
	res_t res_q;

	// Refill the output register when it is free or being taken
	assign fifo_rd = !fifo_empty && (!valid_q || pop);
	assign empty   = !valid_q;
	assign out_res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fifo_rd) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fifo_rd) begin
			res_q <= fifo_res;
		end
	end

	a_refill_valid: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_rd |=> valid_q)
		else $error("output register not loaded after refill");

	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && pop && fifo_empty) |=> !valid_q)
		else $error("result delivered twice");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !pop) |=> (valid_q && $stable(res_q)))
		else $error("waiting result changed");

endmodule

// ===== rtl/ts_pid_payload_extractor.sv =====
// Channel   Handshake        Accepted when        Payload
// input     push / full      push && !full        data_byte
// result    pop / empty      pop && !empty        payload_byte, unit_start,
//                                                 packet_last, continuity_count
// config    wr_en            wr_en                wr_index, wr_data
//
// One byte is taken every cycle that push is high and full is low; the parser
// classifies it in the cycle it is taken and a matching payload byte enters
// a FIFO_DEPTH-entry queue. A result passes through the queue and then the
// output register to the result ports; full is the queue's full flag.
// Reset clears the parser to expect a sync byte, empties the queue and sets
// packet_length to 188, match_pid and psi_mode to 0.
module ts_pid_payload_extractor #(
	parameter int unsigned FIFO_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        pop,
	output logic        empty,
	output logic [7:0]  payload_byte,
	output logic        unit_start,
	output logic        packet_last,
	output logic [3:0]  continuity_count,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [12:0] wr_data
);
	import tpe_pkg::*;

	cfg_t cfg_q;
	logic accept;
	logic emit;
	res_t front_res;
	res_t fifo_res;
	res_t out_res;
	logic fifo_full;
	logic fifo_empty;
	logic fifo_rd;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.match_pid     <= '0;
			cfg_q.psi_mode      <= 1'b0;
			cfg_q.packet_length <= PACKET_LENGTH_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MATCH_PID:     cfg_q.match_pid     <= wr_data;
				REG_PSI_MODE:      cfg_q.psi_mode      <= wr_data[0];
				REG_PACKET_LENGTH: cfg_q.packet_length <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign full   = fifo_full;
	assign accept = push && !fifo_full;

	tpe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.accept    (accept),
		.data_byte (data_byte),
		.emit      (emit),
		.res       (front_res)
	);

	tpe_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (accept && emit),
		.wr_res     (front_res),
		.rd_en      (fifo_rd),
		.rd_res     (fifo_res),
		.fifo_full  (fifo_full),
		.fifo_empty (fifo_empty)
	);

	tpe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (fifo_empty),
		.fifo_res   (fifo_res),
		.fifo_rd    (fifo_rd),
		.pop        (pop),
		.empty      (empty),
		.out_res    (out_res)
	);

	assign payload_byte     = out_res.payload_byte;
	assign unit_start       = out_res.unit_start;
	assign packet_last      = out_res.packet_last;
	assign continuity_count = out_res.continuity_count;

endmodule

// ===== dv/tpe_checker.sv =====
// Watches the stream, result and register ports of the payload extractor,
// tracks its own copy of the packet parser and compares every popped
// transaction against the oldest predicted payload byte.
module tpe_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  data_byte,
	input  logic        pop,
	input  logic        empty,
	input  logic [7:0]  payload_byte,
	input  logic        unit_start,
	input  logic        packet_last,
	input  logic [3:0]  continuity_count,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [12:0] wr_data,
	output int          mismatches,
	output int          pending,
	output int          checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import tpe_pkg::*;

	// Register shadow
	cfg_t       cfg;

	// Parser shadow
	logic [7:0]  pkt_pos;
	logic [12:0] pkt_pid;
	logic        pkt_start;
	logic [1:0]  pkt_afc;
	logic [3:0]  pkt_cc;
	logic [8:0]  skip_to;
	stage_t      stage;

	res_t        payload_q[$];
	res_t        predicted;
	res_t        observed;
	res_t        oldest;
	logic        emits;

	// Advance the parser by one stream byte; hit is set when the byte is payload of the matching PID
	task automatic parse_byte(input logic [7:0] b, output logic hit, output res_t r);
		logic [8:0] pos9;
		logic       ptr_skip;
		hit = 1'b0;
		r = '0;
		pos9 = {1'b0, pkt_pos};
		ptr_skip = cfg.psi_mode && pkt_start;
		case (pkt_pos)
		POS_SYNC: begin
			stage = STG_NONE;
		end
		POS_PID_HI: begin
			pkt_start = b[6];
			pkt_pid[12:8] = b[4:0];
		end
		POS_PID_LO: begin
			pkt_pid[7:0] = b;
		end
		POS_FLAGS: begin
			pkt_afc = b[5:4];
			pkt_cc = b[3:0];
			skip_to = 9'(HEADER_BYTES);
			if (pkt_afc == AFC_ADAPT_PAYLOAD) begin
				stage = STG_ADAPT;
			end else if (pkt_afc == AFC_PAYLOAD_ONLY) begin
				stage = ptr_skip ? STG_PTR : STG_DATA;
			end else begin
				stage = STG_NONE;
			end
		end
		default: begin
			if (stage == STG_ADAPT && pos9 == skip_to) begin
				skip_to = pos9 + 9'd1 + {1'b0, b};
				stage = ptr_skip ? STG_PTR : STG_DATA;
			end else if (stage == STG_PTR && pos9 == skip_to) begin
				skip_to = pos9 + 9'd1 + {1'b0, b};
				stage = STG_DATA;
			end else if (stage == STG_DATA && pos9 >= skip_to && pkt_pid == cfg.match_pid) begin
				hit = 1'b1;
				r.payload_byte = b;
				r.unit_start = pkt_start && (pos9 == skip_to);
				r.packet_last = (pos9 + 9'd1 == {1'b0, cfg.packet_length});
				r.continuity_count = pkt_cc;
			end
		end
		endcase
		// Wrap at the configured length, or at the top of the 8-bit counter
		if (pos9 + 9'd1 >= {1'b0, cfg.packet_length} || pkt_pos == 8'hFF) begin
			pkt_pos = '0;
		end else begin
			pkt_pos = pkt_pos + 8'd1;
		end
	endtask

	function automatic int field_diff(string name, int want, int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.match_pid = '0;
			cfg.psi_mode = 1'b0;
			cfg.packet_length = PACKET_LENGTH_RST;
			pkt_pos = '0;
			pkt_pid = '0;
			pkt_start = 1'b0;
			pkt_afc = '0;
			pkt_cc = '0;
			skip_to = '0;
			stage = STG_NONE;
			payload_q.delete();
			mismatches = 0;
			pending = 0;
			checked = 0;
		end else begin
			// Register writes
			if (wr_en) begin
				case (wr_index)
				REG_MATCH_PID:     cfg.match_pid = wr_data;
				REG_PSI_MODE:      cfg.psi_mode = wr_data[0];
				REG_PACKET_LENGTH: cfg.packet_length = wr_data[7:0];
				default: ;
				endcase
			end

			// Result transaction against the oldest prediction
			if (pop && !empty) begin
				observed = '{payload_byte, unit_start, packet_last, continuity_count};
				if (payload_q.size() == 0) begin
					$display("%0t ns: unexpected result, payload_byte 0x%0h with nothing predicted",
						$time, payload_byte);
					mismatches++;
				end else begin
					oldest = payload_q.pop_front();
					mismatches += field_diff("payload_byte", oldest.payload_byte,
						observed.payload_byte);
					mismatches += field_diff("unit_start", oldest.unit_start,
						observed.unit_start);
					mismatches += field_diff("packet_last", oldest.packet_last,
						observed.packet_last);
					mismatches += field_diff("continuity_count", oldest.continuity_count,
						observed.continuity_count);
				end
				checked++;
			end

			// Stream byte transaction
			if (push && !full) begin
				parse_byte(data_byte, emits, predicted);
				if (emits) begin
					payload_q.push_back(predicted);
				end
			end

			pending = payload_q.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tpe_pkg::*;

	localparam int RESET_CYCLES   = 7;
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int NUM_PHASES     = 9;
	localparam int PHASE_ITEMS    = 64;

	// Adaptation control codes with no payload
	localparam logic [1:0] AFC_RESERVED   = 2'b00;
	localparam logic [1:0] AFC_ADAPT_ONLY = 2'b10;
	localparam logic [7:0] PKT_LEAD       = 8'h47;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  data_byte = '0;
	logic        pop = 1'b0;
	logic        empty;
	logic [7:0]  payload_byte;
	logic        unit_start;
	logic        packet_last;
	logic [3:0]  continuity_count;
	logic        wr_en = 1'b0;
	logic [1:0]  wr_index = '0;
	logic [12:0] wr_data = '0;

	int          mismatches;
	int          pending;
	int          checked;

	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	bit          hold_req = 1'b0;
	int          bytes_sent = 0;
	int          packets_sent = 0;
	int          quiet_cycles = 0;
	int          full_stalls = 0;
	logic [7:0]  stim_len = PACKET_LENGTH_RST;
	logic        stim_psi = 1'b0;
	logic [3:0]  cc_seq = '0;

	ts_pid_payload_extractor DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.data_byte        (data_byte),
		.pop              (pop),
		.empty            (empty),
		.payload_byte     (payload_byte),
		.unit_start       (unit_start),
		.packet_last      (packet_last),
		.continuity_count (continuity_count),
		.wr_en            (wr_en),
		.wr_index         (wr_index),
		.wr_data          (wr_data)
	);

	tpe_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.data_byte        (data_byte),
		.pop              (pop),
		.empty            (empty),
		.payload_byte     (payload_byte),
		.unit_start       (unit_start),
		.packet_last      (packet_last),
		.continuity_count (continuity_count),
		.wr_en            (wr_en),
		.wr_index         (wr_index),
		.wr_data          (wr_data),
		.mismatches       (mismatches),
		.pending          (pending),
		.checked          (checked)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Push one stream byte, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (full) @(posedge clk);
		bytes_sent++;
	endtask

	// Stop pushing and wait until every predicted result has been popped
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
		if (idx == REG_PACKET_LENGTH) stim_len = val[7:0];
		if (idx == REG_PSI_MODE) stim_psi = val[0];
	endtask

	// Build one aligned packet at the current length; only the first nbytes are sent
	task automatic send_packet(input logic [12:0] pid, input logic pusi, input logic [1:0] afc,
			input logic [7:0] alen, input logic [7:0] ptr, input int nbytes);
		logic [7:0] pkt [256];
		int         idx;
		for (int i = 0; i < 256; i++) pkt[i] = 8'($urandom);
		if ($urandom_range(9) != 0) pkt[0] = PKT_LEAD;
		pkt[1] = {1'($urandom), pusi, 1'($urandom), pid[12:8]};
		pkt[2] = pid[7:0];
		pkt[3] = {2'($urandom), afc, cc_seq};
		cc_seq = cc_seq + 4'd1;
		idx = HEADER_BYTES;
		if (afc == AFC_ADAPT_PAYLOAD) begin
			if (idx < stim_len) pkt[idx] = alen;
			idx += alen + 1;
		end
		if ((afc == AFC_PAYLOAD_ONLY || afc == AFC_ADAPT_PAYLOAD) && pusi && stim_psi &&
				idx < stim_len) begin
			pkt[idx] = ptr;
		end
		for (int i = 0; i < nbytes && i < stim_len; i++) send_byte(pkt[i]);
		packets_sent++;
	endtask

	// Mostly matching packets with payload, some neighbors of the PID and no-payload kinds
	task automatic send_random_packet(input logic [12:0] want_pid);
		logic [12:0] pid;
		logic [1:0]  afc;
		logic [7:0]  alen;
		logic [7:0]  ptr;
		int          pick;
		pick = $urandom_range(99);
		if (pick < 75) pid = want_pid;
		else if (pick < 88) pid = want_pid ^ (13'd1 << $urandom_range(12));
		else pid = 13'($urandom);
		pick = $urandom_range(99);
		if (pick < 60) afc = AFC_PAYLOAD_ONLY;
		else if (pick < 85) afc = AFC_ADAPT_PAYLOAD;
		else if (pick < 93) afc = AFC_RESERVED;
		else afc = AFC_ADAPT_ONLY;
		alen = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(stim_len / 4));
		ptr = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(stim_len / 4));
		send_packet(pid, 1'($urandom), afc, alen, ptr, stim_len);
	endtask

	// Result side: random stalls, plus a long hold-off on request
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog on cycles with no transaction of any kind
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || wr_en) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (push && full) full_stalls <= full_stalls + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t ns: no transaction for %0d cycles, %0d results outstanding",
					$time, quiet_cycles, pending);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		logic [12:0] phase_pid;
		int          phase_start;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: PES mode, PID 0 from reset, short packets
		write_reg(REG_PACKET_LENGTH, 13'd8);
		send_packet(13'd0, 1'b1, AFC_PAYLOAD_ONLY, 8'd0, 8'd0, stim_len);
		send_packet(13'd0, 1'b1, AFC_RESERVED, 8'd0, 8'd0, stim_len);
		send_packet(13'd0, 1'b1, AFC_ADAPT_ONLY, 8'd0, 8'd0, stim_len);
		send_packet(13'd0, 1'b1, AFC_ADAPT_PAYLOAD, 8'd1, 8'd0, stim_len);
		// adaptation field runs past the packet end
		send_packet(13'd0, 1'b0, AFC_ADAPT_PAYLOAD, 8'd255, 8'd0, stim_len);
		send_packet(13'd1, 1'b0, AFC_PAYLOAD_ONLY, 8'd0, 8'd0, stim_len);

		// Directed: PSI mode on the top PID, pointer fields
		drain();
		write_reg(REG_PSI_MODE, 13'd1);
		write_reg(REG_MATCH_PID, 13'h1FFF);
		send_packet(13'h1FFF, 1'b1, AFC_PAYLOAD_ONLY, 8'd0, 8'd0, stim_len);
		send_packet(13'h1FFF, 1'b1, AFC_ADAPT_PAYLOAD, 8'd0, 8'd1, stim_len);
		send_packet(13'h1FFF, 1'b0, AFC_PAYLOAD_ONLY, 8'd0, 8'd0, stim_len);
		send_packet(13'h1FFF, 1'b1, AFC_PAYLOAD_ONLY, 8'd0, 8'd200, stim_len);

		// Lengths too short to finish a header
		drain();
		write_reg(REG_PACKET_LENGTH, 13'd3);
		repeat (6) send_byte(8'($urandom));
		drain();
		write_reg(REG_PACKET_LENGTH, 13'd1);
		repeat (3) send_byte(8'($urandom));
		drain();
		write_reg(REG_PACKET_LENGTH, 13'd0);
		repeat (3) send_byte(8'($urandom));

		// Length lowered below the current position mid-packet
		drain();
		write_reg(REG_PACKET_LENGTH, 13'd40);
		send_packet(13'h1FFF, 1'b0, AFC_PAYLOAD_ONLY, 8'd0, 8'd0, 30);
		drain();
		write_reg(REG_PACKET_LENGTH, 13'd20);
		send_byte(8'($urandom));
		send_packet(13'h1FFF, 1'b1, AFC_PAYLOAD_ONLY, 8'd0, 8'd2, stim_len);

		// Back-pressure: result side held off while matching payload keeps coming
		drain();
		write_reg(REG_PACKET_LENGTH, 13'd16);
		hold_req = 1'b1;
		repeat (3) send_packet(13'h1FFF, 1'b0, AFC_PAYLOAD_ONLY, 8'd0, 8'd0, stim_len);

		// Random phases, each with its own register settings and idling mix
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			case (ph % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
			default: begin send_idle_pct = 9; recv_stall_pct = 9; end
			endcase
			if (ph == 0) phase_pid = 13'd0;
			else if (ph == 1) phase_pid = 13'h1FFF;
			else phase_pid = 13'($urandom);
			write_reg(REG_MATCH_PID, phase_pid);
			write_reg(REG_PSI_MODE, (ph < 2) ? 13'(ph) : 13'($urandom_range(1)));
			if (ph == 3) write_reg(REG_PACKET_LENGTH, 13'd188);
			else if (ph == 6) write_reg(REG_PACKET_LENGTH, 13'd255);
			else write_reg(REG_PACKET_LENGTH, 13'($urandom_range(4, 40)));
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_ITEMS) send_random_packet(phase_pid);
		end

		drain();
		$display("Ran %0d stream bytes in %0d packets; %0d payload results were checked.",
			bytes_sent, packets_sent, checked);
		$display("Lengths from 0 to 255, PES and PSI modes; input held off by full for %0d cycles.",
			full_stalls);
		if (mismatches == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/tpe_pkg.sv
rtl/tpe_front.sv
rtl/tpe_fifo.sv
rtl/tpe_back.sv
rtl/ts_pid_payload_extractor.sv
dv/tpe_checker.sv
dv/tb.sv
